@@ sv/tssb_pkg.sv @@
// ----------------------------------------------------------------------------
// tssb_pkg
// Shared types and constants for the three-stack shared node store.
// ----------------------------------------------------------------------------
package tssb_pkg;

  localparam int unsigned STACK_SIZE = 64;
  localparam int unsigned NUM_STACKS = 3;
  localparam int unsigned STORE_CAP  = NUM_STACKS * STACK_SIZE;
  localparam int unsigned IDX_W      = $clog2(STORE_CAP + 1);
  localparam int unsigned ADDR_W     = (STORE_CAP > 1) ? $clog2(STORE_CAP) : 1;
  localparam int unsigned NODE_W     = 32 + 2 * IDX_W;

  // null link: all ones, never a valid slot
  localparam logic [IDX_W-1:0] NIL = '1;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         stack_select;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               stack_empty;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] next;
  } node_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,      // capture input word
    CMD_DECODE,     // flag errors, note top and last slot, read top node
    CMD_PUSH,       // write new node, update top and count
    CMD_LINK_RD,    // read the node whose link is fixed up
    CMD_LINK_WR,    // write it back with the new link
    CMD_POP_A,      // capture top node, unlink it, shrink count
    CMD_MOVE_RD,    // read the node in the last slot
    CMD_MOVE_CAP,   // capture it, set up its prev node fixup
    CMD_MOVE_NEXT,  // set up its next node fixup, or retarget tops
    CMD_MOVE_NODE,  // write moved node into the freed slot
    CMD_PEEK,       // capture top value
    CMD_RESULT      // load output register
  } cmd_t;

  typedef struct packed {
    logic       push_ok;
    logic       top_valid;
    logic       rd_prev_valid;
    logic       move_needed;
    logic       mnext_valid;
    logic [1:0] kind;
  } dp_status_t;

endpackage

@@ sv/tssb_ram.sv @@
// ----------------------------------------------------------------------------
// tssb_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tssb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write on we; registered read of the addressed word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/tssb_datapath.sv @@
// ----------------------------------------------------------------------------
// tssb_datapath
// Stack tops, used count, node store and output word register.
// ----------------------------------------------------------------------------
module tssb_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  tssb_pkg::cmd_t       cmd,
  input  tssb_pkg::in_word_t   in_word,
  input  logic                 out_take,
  output tssb_pkg::dp_status_t st,
  output tssb_pkg::out_word_t  out_word,
  output logic                 out_valid
);
  import tssb_pkg::*;

  logic [IDX_W-1:0]  top [NUM_STACKS];
  logic [IDX_W-1:0]  used;
  in_word_t          req;
  node_t             moved;
  logic [IDX_W-1:0]  t_idx;
  logic [IDX_W-1:0]  last_idx;
  logic [31:0]       value;
  logic [1:0]        status;
  logic [ADDR_W-1:0] lw_addr;
  logic              lw_is_next;
  logic [IDX_W-1:0]  lw_val;

  logic              we;
  logic [ADDR_W-1:0] addr;
  node_t             wdata;
  node_t             rdata;
  node_t             link_node;

  logic              sel_ok;
  logic [IDX_W-1:0]  sel_top;
  logic              sel_empty;

  assign sel_ok    = req.stack_select < 2'(NUM_STACKS);
  assign sel_top   = sel_ok ? top[req.stack_select] : NIL;
  assign sel_empty = (sel_top == NIL);

  assign st.push_ok       = sel_ok && (used < IDX_W'(STORE_CAP));
  assign st.top_valid     = !sel_empty;
  assign st.rd_prev_valid = rdata.prev != NIL;
  assign st.move_needed   = t_idx != last_idx;
  assign st.mnext_valid   = moved.next != NIL;
  assign st.kind          = req.kind;

  tssb_ram #(.WIDTH(NODE_W), .DEPTH(STORE_CAP)) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // node just read with one link replaced
  always_comb begin
    link_node = rdata;
    if (lw_is_next) begin
      link_node.next = lw_val;
    end else begin
      link_node.prev = lw_val;
    end
  end

  // memory port steering
  always_comb begin
    we    = 1'b0;
    addr  = ADDR_W'(t_idx);
    wdata = link_node;
    unique case (cmd)
      CMD_DECODE: begin
        addr = ADDR_W'(sel_top);
      end
      CMD_PUSH: begin
        we    = 1'b1;
        addr  = ADDR_W'(used);
        wdata = '{value: req.push_value, prev: sel_top, next: NIL};
      end
      CMD_LINK_RD: begin
        addr = lw_addr;
      end
      CMD_LINK_WR: begin
        we   = 1'b1;
        addr = lw_addr;
      end
      CMD_MOVE_RD: begin
        addr = ADDR_W'(last_idx);
      end
      CMD_MOVE_NODE: begin
        we    = 1'b1;
        addr  = ADDR_W'(t_idx);
        wdata = moved;
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        top[i] <= NIL;
      end
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_take) begin
        out_valid <= 1'b0;
      end
      unique case (cmd)
        CMD_LATCH: begin
          req    <= in_word;
          status <= ST_OK;
          value  <= '0;
        end
        CMD_DECODE: begin
          t_idx    <= sel_top;
          last_idx <= used - 1'b1;
          if (req.kind == OP_PUSH) begin
            if (!st.push_ok) begin
              status <= ST_FULL;
            end
          end else if (req.kind == OP_POP || req.kind == OP_PEEK) begin
            if (sel_empty) begin
              status <= ST_EMPTY;
            end
          end
        end
        CMD_PUSH: begin
          top[req.stack_select] <= used;
          used                  <= used + 1'b1;
          lw_addr               <= ADDR_W'(sel_top);
          lw_val                <= used;
          lw_is_next            <= 1'b1;
        end
        CMD_POP_A: begin
          value                 <= rdata.value;
          top[req.stack_select] <= rdata.prev;
          used                  <= used - 1'b1;
          lw_addr               <= ADDR_W'(rdata.prev);
          lw_val                <= NIL;
          lw_is_next            <= 1'b1;
        end
        CMD_MOVE_CAP: begin
          moved      <= rdata;
          lw_addr    <= ADDR_W'(rdata.prev);
          lw_val     <= t_idx;
          lw_is_next <= 1'b1;
        end
        CMD_MOVE_NEXT: begin
          if (moved.next != NIL) begin
            lw_addr    <= ADDR_W'(moved.next);
            lw_val     <= t_idx;
            lw_is_next <= 1'b0;
          end else begin
            for (int i = 0; i < NUM_STACKS; i++) begin
              if (top[i] == last_idx) begin
                top[i] <= t_idx;
              end
            end
          end
        end
        CMD_PEEK: begin
          value <= rdata.value;
        end
        CMD_RESULT: begin
          out_valid             <= 1'b1;
          out_word.result_value <= value;
          out_word.stack_empty  <= sel_empty;
          out_word.status       <= status;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= IDX_W'(STORE_CAP)) else $error("used count over capacity");
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> addr < ADDR_W'(STORE_CAP)) else $error("write outside the store");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_take |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_take |=> $stable(out_word)) else $error("result changed");
`endif

endmodule

@@ sv/tssb_ctrl.sv @@
// ----------------------------------------------------------------------------
// tssb_ctrl
// Sequencer for push, pop with compaction, and peek.
// ----------------------------------------------------------------------------
module tssb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_valid,
  input  tssb_pkg::dp_status_t st,
  output tssb_pkg::cmd_t       cmd
);
  import tssb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_PUSH, S_PL_RD, S_PL_WR, S_POPA, S_PV_RD, S_PV_WR,
    S_M_RD, S_M_CAP, S_MP_RD, S_MP_WR, S_MN_SET, S_MN_RD, S_MN_WR, S_MNODE,
    S_PEEK, S_RES
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // command decode per state
  always_comb begin
    unique case (state) inside
      S_IDLE:   cmd = (in_valid) ? CMD_LATCH : CMD_NONE;
      S_DECODE: cmd = CMD_DECODE;
      S_PUSH:   cmd = CMD_PUSH;
      S_PL_RD, S_PV_RD, S_MP_RD, S_MN_RD: cmd = CMD_LINK_RD;
      S_PL_WR, S_PV_WR, S_MP_WR, S_MN_WR: cmd = CMD_LINK_WR;
      S_POPA:   cmd = CMD_POP_A;
      S_M_RD:   cmd = CMD_MOVE_RD;
      S_M_CAP:  cmd = CMD_MOVE_CAP;
      S_MN_SET: cmd = CMD_MOVE_NEXT;
      S_MNODE:  cmd = CMD_MOVE_NODE;
      S_PEEK:   cmd = CMD_PEEK;
      S_RES:    cmd = out_valid ? CMD_NONE : CMD_RESULT;
      default:  cmd = CMD_NONE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          if (st.kind == OP_PUSH) state <= st.push_ok ? S_PUSH : S_RES;
          else if (st.kind == OP_POP && st.top_valid) state <= S_POPA;
          else if (st.kind == OP_PEEK && st.top_valid) state <= S_PEEK;
          else state <= S_RES;
        end
        S_PUSH:   state <= st.top_valid ? S_PL_RD : S_RES;
        S_PL_RD:  state <= S_PL_WR;
        S_PL_WR:  state <= S_RES;
        S_POPA: begin
          if (st.rd_prev_valid) state <= S_PV_RD;
          else state <= st.move_needed ? S_M_RD : S_RES;
        end
        S_PV_RD:  state <= S_PV_WR;
        S_PV_WR:  state <= st.move_needed ? S_M_RD : S_RES;
        S_M_RD:   state <= S_M_CAP;
        S_M_CAP:  state <= st.rd_prev_valid ? S_MP_RD : S_MN_SET;
        S_MP_RD:  state <= S_MP_WR;
        S_MP_WR:  state <= S_MN_SET;
        S_MN_SET: state <= st.mnext_valid ? S_MN_RD : S_MNODE;
        S_MN_RD:  state <= S_MN_WR;
        S_MN_WR:  state <= S_MNODE;
        S_MNODE:  state <= S_RES;
        S_PEEK:   state <= S_RES;
        S_RES:    if (!out_valid) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_res_after: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_RESULT |=> state == S_IDLE) else $error("result step stuck");
  a_latch: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_LATCH |=> state == S_DECODE) else $error("latch lost");
`endif

endmodule

@@ sv/three_stacks_shared_buffer.sv @@
// ----------------------------------------------------------------------------
// three_stacks_shared_buffer
// Three stacks sharing one compacted node store.
// ----------------------------------------------------------------------------
// One word at a time. The node store has a single port with registered read,
// so each step is one read or one write and every link fixup is a read then a
// write. A rejected word or the unused kind goes straight to the result step; a
// peek reads the top node; a push writes the new node and, onto a non-empty
// stack, fixes up the old top's next link; a pop reads and unlinks the top node,
// fixes up the node below it if there is one, moves the last slot into the
// freed one if they differ, and fixes up each linked neighbor of the moved node.
// The result word enters the output register once these steps are done; while
// an earlier result word sits untaken there, the result step waits.
// No clearing pass: a slot's contents are only used after it has been written.
module three_stacks_shared_buffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tssb_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tssb_pkg::out_word_t out_data
);
  import tssb_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  tssb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  tssb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_word   (in_data),
    .out_take  (out_ready),
    .st        (st),
    .out_word  (out_data),
    .out_valid (out_valid)
  );

endmodule
